// ----- rtl/core/wrh_pkg.sv -----
// Package for the wind-rose histogram: payload structs, stage struct and fixed constants.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package wrh_pkg;

  localparam int unsigned DIR_W       = 13;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned LIMIT_W     = 15;
  localparam int unsigned SEC_FIELD_W = 4;
  localparam int unsigned BIN_W       = 3;
  localparam int unsigned OUT_COUNT_W = 32;
  localparam int unsigned SPEED_BINS  = 5;
  localparam int unsigned MULT_K      = 26;

  localparam logic [DIR_W-1:0] FULL_CIRCLE = 13'd5760;

  localparam logic [BIN_W-1:0] SPEED_BIN_ZERO  = 3'd0;
  localparam logic [BIN_W-1:0] SPEED_BIN_LOW   = 3'd1;
  localparam logic [BIN_W-1:0] SPEED_BIN_MID   = 3'd2;
  localparam logic [BIN_W-1:0] SPEED_BIN_HIGH  = 3'd3;
  localparam logic [BIN_W-1:0] SPEED_BIN_ABOVE = 3'd4;

  localparam logic [1:0] REG_LIMIT_LOW  = 2'd0;
  localparam logic [1:0] REG_LIMIT_MID  = 2'd1;
  localparam logic [1:0] REG_LIMIT_HIGH = 2'd2;

  localparam logic [LIMIT_W-1:0] LIMIT_LOW_RST  = 15'd80;
  localparam logic [LIMIT_W-1:0] LIMIT_MID_RST  = 15'd240;
  localparam logic [LIMIT_W-1:0] LIMIT_HIGH_RST = 15'd400;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic signed [SPEED_W-1:0] wind_speed;
    logic [DIR_W-1:0]          wind_direction;
    logic [SEC_FIELD_W-1:0]    read_sector;
    logic [BIN_W-1:0]          read_speed_bin;
  } wrh_in_t;

  typedef struct packed {
    logic                   counted;
    logic [SEC_FIELD_W-1:0] sector;
    logic [BIN_W-1:0]       speed_bin;
    logic [OUT_COUNT_W-1:0] bin_count;
  } wrh_out_t;

  typedef struct packed {
    logic                   valid;
    logic                   req_type;
    logic                   dir_ok;
    logic [BIN_W-1:0]       speed_bin;
    logic [SEC_FIELD_W-1:0] read_sector;
    logic [BIN_W-1:0]       read_speed_bin;
  } wrh_stage_t;

endpackage

`default_nettype wire

// ----- rtl/core/wrh_classify.sv -----
// First pipeline stage: speed binning against the limits and sector number by constant reciprocal.
// Depends on wrh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wrh_classify #(
  parameter int SECTORS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                valid_i,
  input  wire wrh_pkg::wrh_in_t                    in_data_i,
  input  wire logic [wrh_pkg::LIMIT_W-1:0]         limit_low_i,
  input  wire logic [wrh_pkg::LIMIT_W-1:0]         limit_mid_i,
  input  wire logic [wrh_pkg::LIMIT_W-1:0]         limit_high_i,
  output wrh_pkg::wrh_stage_t                      stage_o,
  output logic [$clog2(SECTORS)-1:0]               sector_o
);

  localparam int unsigned SEC_W   = $clog2(SECTORS);
  localparam logic [63:0] SEC_MUL =
    ((64'd1 << wrh_pkg::MULT_K) * SECTORS + 64'(wrh_pkg::FULL_CIRCLE) - 64'd1) /
    64'(wrh_pkg::FULL_CIRCLE);
  localparam int unsigned MUL_W  = $clog2(SEC_MUL + 64'd1);
  localparam int unsigned PROD_W = wrh_pkg::DIR_W + MUL_W;

  logic signed [16:0]            speed_s;
  logic signed [16:0]            lo_s;
  logic signed [16:0]            mi_s;
  logic signed [16:0]            hi_s;
  logic [wrh_pkg::BIN_W-1:0]     speed_bin;
  logic [MUL_W-1:0]              mul_c;
  logic [PROD_W-1:0]             prod;

  logic                          valid_r;
  logic                          req_type_r;
  logic                          dir_ok_r;
  logic [wrh_pkg::BIN_W-1:0]     speed_bin_r;
  logic [wrh_pkg::SEC_FIELD_W-1:0] read_sector_r;
  logic [wrh_pkg::BIN_W-1:0]     read_speed_bin_r;
  logic [PROD_W-1:0]             prod_r;

  assign speed_s = {in_data_i.wind_speed[wrh_pkg::SPEED_W-1], in_data_i.wind_speed};
  assign lo_s    = {2'b00, limit_low_i};
  assign mi_s    = {2'b00, limit_mid_i};
  assign hi_s    = {2'b00, limit_high_i};

  always_comb begin
    if (speed_s == 17'sd0) begin
      speed_bin = wrh_pkg::SPEED_BIN_ZERO;
    end else if (speed_s > 17'sd0 && speed_s <= lo_s) begin
      speed_bin = wrh_pkg::SPEED_BIN_LOW;
    end else if (speed_s > lo_s && speed_s <= mi_s) begin
      speed_bin = wrh_pkg::SPEED_BIN_MID;
    end else if (speed_s > mi_s && speed_s <= hi_s) begin
      speed_bin = wrh_pkg::SPEED_BIN_HIGH;
    end else begin
      speed_bin = wrh_pkg::SPEED_BIN_ABOVE;
    end
  end

  // The reciprocal is rounded up; the error stays below one part in 5760 for any valid direction.
  assign mul_c = SEC_MUL[MUL_W-1:0];
  assign prod  = PROD_W'(in_data_i.wind_direction) * PROD_W'(mul_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    req_type_r       <= in_data_i.req_type;
    dir_ok_r         <= (in_data_i.wind_direction < wrh_pkg::FULL_CIRCLE);
    speed_bin_r      <= speed_bin;
    read_sector_r    <= in_data_i.read_sector;
    read_speed_bin_r <= in_data_i.read_speed_bin;
    prod_r           <= prod;
  end

  always_comb begin
    stage_o.valid          = valid_r;
    stage_o.req_type       = req_type_r;
    stage_o.dir_ok         = dir_ok_r;
    stage_o.speed_bin      = speed_bin_r;
    stage_o.read_sector    = read_sector_r;
    stage_o.read_speed_bin = read_speed_bin_r;
  end

  assign sector_o = prod_r[wrh_pkg::MULT_K +: SEC_W];

endmodule

`default_nettype wire

// ----- rtl/core/wind_rose_histogram.sv -----
// Top level of the wind-rose histogram: configuration registers, counter memory and update stage.
// Depends on wrh_pkg and wrh_classify.
`timescale 1ns / 1ps
`default_nettype none

// Usage.
// Items arrive on in_data and are transferred at a clock edge where start is high and busy is low.
// A sample item (req_type 0) adds one, saturating, to the counter of its direction sector and speed
// bin, and is not counted if its direction is not below 5760; a read item (req_type 1) returns one
// counter and changes nothing. Every item yields exactly one result. The result is on out_data
// with out_valid high for a single cycle; the receiver cannot stall. One item is taken every clock
// cycle while busy is low. The counters live in one memory with a registered read port and a
// write port; each item reads its counter in the second stage and writes it back in the third,
// and a write-to-read bypass covers consecutive items on the same counter, so the memory's single
// read-modify-write per cycle sets the throughput. After reset busy stays high while the memory
// is cleared one counter per cycle; configuration writes are taken throughout. The speed limits
// are written over the APB port at byte addresses 0, 4 and 8; the user must write them only while
// no item is in flight, as the block itself does not enforce this.
module wind_rose_histogram #(
  parameter int SECTORS     = 16,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire wrh_pkg::wrh_in_t  in_data,
  output logic                   out_valid,
  output wrh_pkg::wrh_out_t      out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned SEC_W = $clog2(SECTORS);
  localparam int unsigned DEPTH = SECTORS * wrh_pkg::SPEED_BINS;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [6:0]  SECTORS_L = 7'(SECTORS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  logic [wrh_pkg::LIMIT_W-1:0] limit_low_r;
  logic [wrh_pkg::LIMIT_W-1:0] limit_mid_r;
  logic [wrh_pkg::LIMIT_W-1:0] limit_high_r;
  logic                        cfg_write;

  logic                        clr_active_r;
  logic [IDX_W-1:0]            clr_idx_r;

  wrh_pkg::wrh_stage_t         s1;
  logic [SEC_W-1:0]            s1_sector;
  logic [IDX_W-1:0]            s1_idx_sample;
  logic [IDX_W-1:0]            s1_idx_read;
  logic                        s1_read_ok;

  logic [COUNT_WIDTH-1:0]      bin_mem [DEPTH];
  logic [COUNT_WIDTH-1:0]      rd_data_r;

  logic                        s2_valid_r;
  logic                        s2_write_r;
  logic                        s2_hit_r;
  logic [IDX_W-1:0]            s2_idx_r;
  logic [wrh_pkg::SEC_FIELD_W-1:0] s2_sector_r;
  logic [wrh_pkg::BIN_W-1:0]   s2_bin_r;

  logic                        wr_en_r;
  logic [IDX_W-1:0]            wr_idx_r;
  logic [COUNT_WIDTH-1:0]      wr_val_r;

  logic [COUNT_WIDTH-1:0]      cur_count;
  logic [COUNT_WIDTH-1:0]      new_count;
  logic [COUNT_WIDTH-1:0]      res_count;

  logic                        out_valid_r;
  wrh_pkg::wrh_out_t           out_data_r;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_low_r  <= wrh_pkg::LIMIT_LOW_RST;
      limit_mid_r  <= wrh_pkg::LIMIT_MID_RST;
      limit_high_r <= wrh_pkg::LIMIT_HIGH_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        wrh_pkg::REG_LIMIT_LOW:  limit_low_r  <= pwdata[wrh_pkg::LIMIT_W-1:0];
        wrh_pkg::REG_LIMIT_MID:  limit_mid_r  <= pwdata[wrh_pkg::LIMIT_W-1:0];
        wrh_pkg::REG_LIMIT_HIGH: limit_high_r <= pwdata[wrh_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      wrh_pkg::REG_LIMIT_LOW:  prdata = {17'd0, limit_low_r};
      wrh_pkg::REG_LIMIT_MID:  prdata = {17'd0, limit_mid_r};
      wrh_pkg::REG_LIMIT_HIGH: prdata = {17'd0, limit_high_r};
      default:                 prdata = 32'd0;
    endcase
  end

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
    end else if (clr_active_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (clr_idx_r == LAST_IDX) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign busy = clr_active_r;

  wrh_classify #(
    .SECTORS (SECTORS)
  ) u_classify (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid_i      (start && !clr_active_r),
    .in_data_i    (in_data),
    .limit_low_i  (limit_low_r),
    .limit_mid_i  (limit_mid_r),
    .limit_high_i (limit_high_r),
    .stage_o      (s1),
    .sector_o     (s1_sector)
  );

  // Second stage: counter address and memory read.
  assign s1_idx_sample = (IDX_W'(s1_sector) << 2) + IDX_W'(s1_sector) + IDX_W'(s1.speed_bin);
  assign s1_idx_read   = (IDX_W'(s1.read_sector) << 2) + IDX_W'(s1.read_sector)
                         + IDX_W'(s1.read_speed_bin);
  assign s1_read_ok    = ({3'd0, s1.read_sector} < SECTORS_L)
                         && (s1.read_speed_bin < 3'(wrh_pkg::SPEED_BINS));

  always_ff @(posedge clk) begin
    if (s1.req_type == wrh_pkg::REQ_READ) begin
      rd_data_r <= bin_mem[s1_idx_read];
    end else begin
      rd_data_r <= bin_mem[s1_idx_sample];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1.req_type == wrh_pkg::REQ_READ) begin
      s2_write_r  <= 1'b0;
      s2_hit_r    <= s1_read_ok;
      s2_idx_r    <= s1_idx_read;
      s2_sector_r <= s1.read_sector;
      s2_bin_r    <= s1.read_speed_bin;
    end else begin
      s2_write_r  <= s1.dir_ok;
      s2_hit_r    <= 1'b0;
      s2_idx_r    <= s1_idx_sample;
      s2_sector_r <= s1.dir_ok ? wrh_pkg::SEC_FIELD_W'(s1_sector) : '0;
      s2_bin_r    <= s1.speed_bin;
    end
  end

  // Third stage: bypass, saturating increment and write-back.
  assign cur_count = (wr_en_r && (wr_idx_r == s2_idx_r)) ? wr_val_r : rd_data_r;
  assign new_count = (&cur_count) ? cur_count : cur_count + 1'b1;

  always_comb begin
    if (s2_write_r) begin
      res_count = new_count;
    end else if (s2_hit_r) begin
      res_count = cur_count;
    end else begin
      res_count = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      bin_mem[clr_idx_r] <= '0;
    end else if (s2_valid_r && s2_write_r) begin
      bin_mem[s2_idx_r] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_en_r     <= s2_valid_r && s2_write_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    wr_idx_r             <= s2_idx_r;
    wr_val_r             <= new_count;
    out_data_r.counted   <= s2_write_r;
    out_data_r.sector    <= s2_sector_r;
    out_data_r.speed_bin <= s2_bin_r;
    out_data_r.bin_count <= wrh_pkg::OUT_COUNT_W'(res_count);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/wrh_checker.sv -----
// Port-level checker for the wind-rose histogram and the bind that attaches it to the top level.
// Depends on wrh_pkg and wind_rose_histogram.
`timescale 1ns / 1ps
`default_nettype none

module wrh_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire wrh_pkg::wrh_in_t  in_data,
  input wire logic              out_valid,
  input wire wrh_pkg::wrh_out_t out_data
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##3 out_valid)
    else $error("no result three cycles after a transfer");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 3))
    else $error("result without a matching transfer");

  a_discard: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_data.req_type == wrh_pkg::REQ_SAMPLE)
      && (in_data.wind_direction >= wrh_pkg::FULL_CIRCLE)
    |-> ##3 (!out_data.counted && out_data.sector == '0 && out_data.bin_count == '0))
    else $error("discarded sample was counted");

  a_counted_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.counted |-> out_data.bin_count != '0)
    else $error("counted sample reports an empty bin");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> busy)
    else $error("block not busy after reset");

endmodule

bind wind_rose_histogram wrh_checker u_wrh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
